// ===== rtl/hpr_pkg.sv =====
package hpr_pkg;

  localparam int unsigned BINS        = 256;
  localparam int unsigned COUNT_BITS  = 24;

  localparam int unsigned BIN_COUNT_W = 24;
  localparam int unsigned BOUND_W     = 8;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned PCT_W       = 14;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam int unsigned IDX_W       = $clog2(BINS);
  localparam int unsigned LOADED_W    = $clog2(BINS + 1);
  localparam int unsigned PROD_W      = TOTAL_W + PCT_W;

  localparam logic [PCT_W-1:0] PCT_SCALE   = PCT_W'(10000);
  localparam logic [PCT_W-1:0] PCT_RESET   = PCT_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERCENT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PERCENT = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_LO_THR,
    ST_LO_RD,
    ST_LO_ACC,
    ST_LO_CMP,
    ST_HI_THR,
    ST_HI_RD,
    ST_HI_ACC,
    ST_HI_CMP,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/hpr_if.sv =====
interface hpr_bin_if;
  import hpr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BIN_COUNT_W-1:0] bin_count;
  logic                   last_bin;

  modport source (output valid, output bin_count, output last_bin, input ready);
  modport sink   (input valid, input bin_count, input last_bin, output ready);
endinterface

interface hpr_res_if;
  import hpr_pkg::*;

  logic               valid;
  logic               ready;
  logic [BOUND_W-1:0] low_bound;
  logic [BOUND_W-1:0] high_bound;
  logic [TOTAL_W-1:0] pixel_total;

  modport source (output valid, output low_bound, output high_bound, output pixel_total,
                  input ready);
  modport sink   (input valid, input low_bound, input high_bound, input pixel_total,
                  output ready);
endinterface

// ===== rtl/histogram_percentile_range.sv =====
// Percentile clip range of a histogram.
// bin_i carries one histogram bin per beat, lowest bin first; last_bin marks
// the final bin, and the BINS-th bin ends a histogram on its own. In the load
// state one bin is taken per cycle and written to an on-chip bin store.
// After the final bin the block stops taking beats and runs two scans with a
// single shared 32x14 multiplier and a 32-bit accumulator: a threshold step
// forms total*percent, then each visited bin takes three steps (store read,
// accumulate, scaled compare). The low scan walks up from bin 0, the high
// scan walks down from the last bin to bin 1.
// res_o holds low_bound, high_bound and pixel_total in an output register, so
// loading of the next histogram goes on while a result waits; only a second
// finished histogram waits for the receiver to take the first result.
// cfg_we_i writes low_percent (index 0) or high_percent (index 1); write
// only while idle. Reset sets both percents to 100 and empties the block;
// the bin store needs no clearing since every bin is written before use.
module histogram_percentile_range (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hpr_pkg::PCT_W-1:0]       cfg_data_i,
  hpr_bin_if.sink                         bin_i,
  hpr_res_if.source                       res_o
);
  import hpr_pkg::*;

  // bin store
  logic [COUNT_BITS-1:0] mem_q [BINS];
  logic [COUNT_BITS-1:0] rdata_q;

  state_e                state_q, state_d;
  logic [PCT_W-1:0]      low_pct_q, high_pct_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [LOADED_W-1:0]   loaded_q;
  logic [IDX_W-1:0]      last_idx_q;
  logic [IDX_W-1:0]      idx_q;
  logic [TOTAL_W-1:0]    sum_q;
  logic [PROD_W-1:0]     thr_q;
  logic [IDX_W-1:0]      lo_q, hi_q;

  logic                  res_valid_q;
  logic [BOUND_W-1:0]    res_lo_q, res_hi_q;
  logic [TOTAL_W-1:0]    res_total_q;

  logic                  in_beat;
  logic                  load_end;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] cnt;
  logic [TOTAL_W-1:0]    mul_a;
  logic [PCT_W-1:0]      mul_b;
  logic [PROD_W-1:0]     prod;
  logic                  past_thr;
  logic                  res_free;

  assign bin_i.ready = (state_q == ST_LOAD);
  assign in_beat     = bin_i.valid && bin_i.ready;
  assign wr_addr     = loaded_q[IDX_W-1:0];
  assign cnt         = bin_i.bin_count[COUNT_BITS-1:0];
  assign load_end    = bin_i.last_bin || (loaded_q == LOADED_W'(BINS - 1));

  // shared multiplier: threshold in the THR states, scaled running sum otherwise
  always_comb begin
    mul_a = sum_q;
    mul_b = PCT_SCALE;
    case (state_q)
      ST_LO_THR: begin
        mul_a = total_q;
        mul_b = low_pct_q;
      end
      ST_HI_THR: begin
        mul_a = total_q;
        mul_b = high_pct_q;
      end
      default: begin
        mul_a = sum_q;
        mul_b = PCT_SCALE;
      end
    endcase
  end

  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign past_thr = prod > thr_q;
  assign res_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:   if (in_beat && load_end) state_d = ST_LO_THR;
      ST_LO_THR: state_d = ST_LO_RD;
      ST_LO_RD:  state_d = ST_LO_ACC;
      ST_LO_ACC: state_d = ST_LO_CMP;
      ST_LO_CMP: begin
        if (past_thr || idx_q == last_idx_q) state_d = ST_HI_THR;
        else                                  state_d = ST_LO_RD;
      end
      ST_HI_THR: begin
        if (last_idx_q == '0) state_d = ST_DONE;
        else                  state_d = ST_HI_RD;
      end
      ST_HI_RD:  state_d = ST_HI_ACC;
      ST_HI_ACC: state_d = ST_HI_CMP;
      ST_HI_CMP: begin
        if (past_thr || idx_q == IDX_W'(1)) state_d = ST_DONE;
        else                                 state_d = ST_HI_RD;
      end
      ST_DONE:   if (res_free) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // store write on each bin beat, registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      mem_q[wr_addr] <= cnt;
    end
    rdata_q <= mem_q[idx_q];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_pct_q  <= PCT_RESET;
      high_pct_q <= PCT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_PERCENT:  low_pct_q  <= cfg_data_i;
        CFG_HIGH_PERCENT: high_pct_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // load counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      loaded_q <= '0;
    end else if (in_beat) begin
      total_q  <= total_q + TOTAL_W'(cnt);
      loaded_q <= loaded_q + LOADED_W'(1);
    end else if (state_q == ST_DONE && res_free) begin
      // drop the finished histogram
      total_q  <= '0;
      loaded_q <= '0;
    end
  end

  // scan datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      sum_q      <= '0;
      thr_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      last_idx_q <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_beat) last_idx_q <= wr_addr;
          idx_q <= '0;
        end
        ST_LO_THR: begin
          thr_q <= prod;
          sum_q <= '0;
          idx_q <= '0;
        end
        ST_LO_ACC: sum_q <= sum_q + TOTAL_W'(rdata_q);
        ST_LO_CMP: begin
          if (past_thr) begin
            lo_q <= (idx_q == '0) ? '0 : idx_q - IDX_W'(1);
          end else if (idx_q == last_idx_q) begin
            lo_q <= last_idx_q;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_HI_THR: begin
          thr_q <= prod;
          sum_q <= '0;
          hi_q  <= '0;
          idx_q <= last_idx_q;
        end
        ST_HI_ACC: sum_q <= sum_q + TOTAL_W'(rdata_q);
        ST_HI_CMP: begin
          if (past_thr) begin
            hi_q <= idx_q;
          end else if (idx_q != IDX_W'(1)) begin
            idx_q <= idx_q - IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register: hold until the receiver takes the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && res_free) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && res_free) begin
      res_lo_q    <= BOUND_W'(lo_q);
      res_hi_q    <= BOUND_W'(hi_q);
      res_total_q <= total_q;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.low_bound   = res_lo_q;
  assign res_o.high_bound  = res_hi_q;
  assign res_o.pixel_total = res_total_q;

endmodule

// ===== verif/histogram_percentile_range_tb.sv =====
module histogram_percentile_range_tb;
  import hpr_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned MAX_IDLE      = 16;
  localparam int unsigned RANDOM_BEATS  = 800;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned QUIET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned LIMIT_CYCLES  = 500000;
  localparam int unsigned MAX_PRINTS    = 40;

  typedef struct packed {
    logic [BOUND_W-1:0] low_bound;
    logic [BOUND_W-1:0] high_bound;
    logic [TOTAL_W-1:0] pixel_total;
  } clip_t;

  // Tracks the histogram being loaded and the clip bounds still owed by the block.
  class clip_tracker;
    logic [COUNT_BITS-1:0] bin_store [BINS];
    int unsigned           bins_loaded;
    logic [TOTAL_W-1:0]    bin_total;
    logic [PCT_W-1:0]      low_pct;
    logic [PCT_W-1:0]      high_pct;
    clip_t                 bounds_due [$];
    int unsigned           mismatches;
    int unsigned           histograms;
    int unsigned           full_size;
    int unsigned           checked;

    function new();
      low_pct     = PCT_RESET;
      high_pct    = PCT_RESET;
      bins_loaded = 0;
      bin_total   = '0;
      mismatches  = 0;
      histograms  = 0;
      full_size   = 0;
      checked     = 0;
    endfunction

    function clip_t predict_bounds();
      clip_t              res;
      logic [TOTAL_W-1:0] sum;
      logic [63:0]        lo_limit;
      logic [63:0]        hi_limit;
      int unsigned        b;
      bit                 hit;
      lo_limit        = 64'(bin_total) * 64'(low_pct);
      hi_limit        = 64'(bin_total) * 64'(high_pct);
      res.pixel_total = bin_total;
      // upward scan; without a stop the bound is the last bin
      res.low_bound = BOUND_W'(bins_loaded - 1);
      sum = '0;
      hit = 1'b0;
      for (b = 0; b < bins_loaded && !hit; b++) begin
        sum += TOTAL_W'(bin_store[b]);
        if (64'(sum) * 64'(PCT_SCALE) > lo_limit) begin
          hit           = 1'b1;
          res.low_bound = BOUND_W'(b == 0 ? 0 : b - 1);
        end
      end
      // downward scan stops short of bin 0
      res.high_bound = '0;
      sum = '0;
      hit = 1'b0;
      for (b = bins_loaded - 1; b > 0 && !hit; b--) begin
        sum += TOTAL_W'(bin_store[b]);
        if (64'(sum) * 64'(PCT_SCALE) > hi_limit) begin
          hit            = 1'b1;
          res.high_bound = BOUND_W'(b);
        end
      end
      return res;
    endfunction

    function void take_bin(logic [BIN_COUNT_W-1:0] count, logic last);
      bin_store[bins_loaded] = count[COUNT_BITS-1:0];
      bin_total += TOTAL_W'(count[COUNT_BITS-1:0]);
      bins_loaded++;
      if (last || bins_loaded == BINS) begin
        if (bins_loaded == BINS) full_size++;
        bounds_due.push_back(predict_bounds());
        histograms++;
        bins_loaded = 0;
        bin_total   = '0;
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_bounds(clip_t got);
      clip_t want;
      checked++;
      if (bounds_due.size() == 0) begin
        report($sformatf("unexpected result low %0d high %0d total %0d",
                         got.low_bound, got.high_bound, got.pixel_total));
      end else begin
        want = bounds_due.pop_front();
        if (got.low_bound !== want.low_bound)
          report($sformatf("low_bound %0d, want %0d", got.low_bound, want.low_bound));
        if (got.high_bound !== want.high_bound)
          report($sformatf("high_bound %0d, want %0d", got.high_bound, want.high_bound));
        if (got.pixel_total !== want.pixel_total)
          report($sformatf("pixel_total %0d, want %0d", got.pixel_total, want.pixel_total));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [PCT_W-1:0]     cfg_data;

  hpr_bin_if bin_if ();
  hpr_res_if res_if ();

  histogram_percentile_range dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .bin_i      (bin_if),
    .res_o      (res_if)
  );

  clip_tracker tracker;
  bit          steady;       // no sender gaps for the current histogram
  int unsigned beats_sent;
  int unsigned settings;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Draw a bin count: full-range values most often, with zeros, tiny counts,
  // shifted-down values and saturated bins mixed in.
  function automatic logic [BIN_COUNT_W-1:0] random_count(int unsigned zero_pct);
    logic [BIN_COUNT_W-1:0] raw;
    raw = BIN_COUNT_W'($urandom);
    if ($urandom_range(0, 99) < zero_pct) return '0;
    case ($urandom_range(0, 7))
      0: return '1;
      1, 2: return BIN_COUNT_W'(raw[7:0]);
      3, 4: return raw >> $urandom_range(0, BIN_COUNT_W - 1);
      default: return raw;
    endcase
  endfunction

  // Keep most histograms short so scans stay cheap; a few reach full size.
  function automatic int unsigned random_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) return BINS;
    if (pick < 6) return $urandom_range(17, 128);
    return $urandom_range(1, 16);
  endfunction

  // Mostly in range; now and then above 10000 so neither scan can stop.
  function automatic logic [PCT_W-1:0] random_percent();
    if ($urandom_range(0, 7) == 0) return PCT_W'($urandom_range(10001, 16383));
    return PCT_W'($urandom_range(0, 10000));
  endfunction

  // Send one bin beat after a random gap; scramble the payload while idle.
  task automatic send_bin(logic [BIN_COUNT_W-1:0] count, logic last);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      bin_if.valid     <= 1'b0;
      bin_if.bin_count <= BIN_COUNT_W'($urandom);
      bin_if.last_bin  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    bin_if.valid     <= 1'b1;
    bin_if.bin_count <= count;
    bin_if.last_bin  <= last;
    @(posedge clk);
    while (!bin_if.ready) @(posedge clk);
    tracker.take_bin(count, last);
    beats_sent++;
  endtask

  task automatic send_list(logic [BIN_COUNT_W-1:0] counts [$]);
    int unsigned b;
    steady = ($urandom_range(0, 3) == 0);
    for (b = 0; b < counts.size(); b++) send_bin(counts[b], b == counts.size() - 1);
  endtask

  // A full-size histogram may end on the bin limit alone, so end_flag may be 0 there.
  task automatic send_histogram(int unsigned len, logic end_flag, int unsigned zero_pct);
    int unsigned b;
    steady = ($urandom_range(0, 3) == 0);
    for (b = 0; b < len; b++)
      send_bin(random_count(zero_pct), (b == len - 1) ? end_flag : 1'b0);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    bin_if.valid <= 1'b0;
    while (tracker.bounds_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write both percent registers on an idle block.
  task automatic set_percents(logic [PCT_W-1:0] lo, logic [PCT_W-1:0] hi);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_LOW_PERCENT;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= CFG_HIGH_PERCENT;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tracker.low_pct  = lo;
    tracker.high_pct = hi;
    settings++;
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned len;
    int unsigned phase_end;
    int unsigned zero_pct;
    tracker    = new();
    beats_sent = 0;
    settings   = 1;
    steady     = 1'b0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_LOW_PERCENT;
    cfg_data         <= '0;
    bin_if.valid     <= 1'b0;
    bin_if.bin_count <= '0;
    bin_if.last_bin  <= 1'b0;
    res_if.ready     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting at the reset percents.
    // Single bin: both bounds collapse to 0, at either count extreme.
    send_list('{24'hFFFFFF});
    send_list('{24'h000000});
    // All-zero histogram: neither scan stops, low bound is the last bin.
    send_list('{0, 0, 0, 0});
    send_list('{24'hFFFFFF, 0, 0, 24'hFFFFFF, 1});
    send_list('{24'hAAAAAA, 24'h555555});
    // Zero tails: the first nonzero bin from each side stops the scan.
    set_percents('0, '0);
    send_list('{0, 5, 0, 7});
    // Full tails: the running sum can never exceed the total.
    set_percents(PCT_W'(10000), PCT_W'(10000));
    send_list('{3, 4, 5});
    // Percent above 10000 is taken as is.
    set_percents('1, '1);
    send_list('{9, 24'hFFFFFF, 2});

    // Random part: one phase per percent setting, extremes first.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_percents(PCT_W'(5000), PCT_W'(250));
        1: set_percents(PCT_W'(1), PCT_W'(9999));
        2: set_percents(PCT_W'(10000), PCT_W'(0));
        3: set_percents(PCT_W'(0), PCT_W'(10000));
        default: set_percents(random_percent(), random_percent());
      endcase
      phase_end = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
      while (beats_sent < phase_end) begin
        len      = random_length();
        zero_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 95);
        send_histogram(len, (len == BINS) ? 1'($urandom) : 1'b1, zero_pct);
        // now and then let the pipeline run dry before the next histogram
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d histograms (%0d at full size) from %0d bin beats over %0d percent settings",
             tracker.histograms, tracker.full_size, beats_sent, settings);
    $display("checked %0d clip results, %0d mismatches", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.bounds_due.size() == 0) begin
      $display("PASS histogram_percentile_range");
    end else begin
      $display("FAIL histogram_percentile_range");
    end
    $finish;
  end

  // Result side: stall at random, with calm stretches of back-to-back beats.
  initial begin : result_side
    int unsigned stall;
    int unsigned calm;
    clip_t       got;
    calm = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    stall = $urandom_range(0, MAX_IDLE);
    forever begin
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got.low_bound   = res_if.low_bound;
      got.high_bound  = res_if.high_bound;
      got.pixel_total = res_if.pixel_total;
      tracker.check_bounds(got);
      if (calm != 0) begin
        calm--;
        stall = 0;
      end else begin
        if ($urandom_range(0, 7) == 0) calm = 10;
        stall = $urandom_range(0, MAX_IDLE);
      end
    end
  end

  // Bound the run well past the slowest legal schedule.
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("FAIL histogram_percentile_range");
    $finish;
  end

endmodule
